FILE: hdl/tmhq_pkg.sv
package tmhq_pkg;

  localparam int MaxTimersDefault = 32;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_EXPIRE = 2'd2;
  localparam logic [1:0] ACT_WAIT   = 2'd3;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_CANCEL = 3'd1;
  localparam logic [2:0] KIND_FIRED  = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_WAIT   = 3'd4;

  localparam logic [47:0] T48_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] WAIT_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         action;
    logic [47:0]        now_ms;
    logic [31:0]        delay_ms;
    logic [31:0]        timer_handle;
    logic signed [31:0] wait_cap_ms;
  } tmhq_in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        timer_id;
    logic signed [31:0] wait_ms;
    logic               ok_flag;
    logic               last;
  } tmhq_out_t;

  // Sequencer states: every heap step reads one slot, then acts on it.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_CAN_RD,
    ST_CAN_CMP,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_EXP_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_WAIT_RD,
    ST_WAIT_CMP
  } tmhq_state_t;

endpackage

FILE: hdl/timer_min_heap_queue.sv
// Channel | Direction | Handshake             | Payload
// in_     | input     | start & !busy         | tmhq_in_t
// out_    | output    | out_valid, one cycle  | tmhq_out_t
//
// Add: climbs level by level from the new last slot, writes the root at once into an
// empty heap, and is refused when the heap is full. Cancel: compares slots in order
// until a match or the end. Expire: pops each due entry and sinks the last entry.
// Wait query reads the top slot. One heap slot is read per cycle from the single
// storage array. Reset clears the count and sets the next id to one. The receiver
// cannot stall: each result shows for one cycle.
module timer_min_heap_queue #(
  parameter int MAX_TIMERS = tmhq_pkg::MaxTimersDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tmhq_pkg::tmhq_in_t  in_item,
  output logic                out_valid,
  output tmhq_pkg::tmhq_out_t out_item
);
  import tmhq_pkg::*;

  localparam int AW = $clog2(MAX_TIMERS);
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int EW = 48 + 32 + 1;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [AW+1:0] kid_t;

  // Heap slot memory: deadline, id, cancel mark.
  logic [EW-1:0] heap_mem [MAX_TIMERS];
  logic [EW-1:0] rd_data_r;
  addr_t         rd_addr;
  logic          wr_en;
  addr_t         wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= heap_mem[rd_addr];
  end

  tmhq_state_t state_r, state_nxt;
  cnt_t        count_r, count_nxt;
  logic [31:0] next_id_r, next_id_nxt;
  tmhq_in_t    req_r, req_nxt;
  addr_t       pos_r, pos_nxt;
  addr_t       best_r, best_nxt;
  logic [EW-1:0] cur_r, cur_nxt;
  logic [EW-1:0] bst_r, bst_nxt;
  cnt_t        idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  tmhq_out_t   out_r, out_nxt;
  logic [31:0] wait_t;

  // Shared compare unit on deadlines.
  logic [47:0] cmp_a, cmp_b;
  logic        a_lt_b;
  assign a_lt_b = cmp_a < cmp_b;

  logic [48:0] dl_sum;
  logic [47:0] diff;
  assign dl_sum = {1'b0, req_r.now_ms} + {17'd0, req_r.delay_ms};
  assign diff   = rd_data_r[EW-1 -: 48] - req_r.now_ms;

  addr_t parent;
  assign parent = addr_t'((pos_r - addr_t'(1)) >> 1);

  // Child positions are kept wide enough that they never wrap.
  kid_t lchild, rchild;
  logic has_left, has_right;
  assign lchild    = {1'b0, pos_r, 1'b1};
  assign rchild    = lchild + kid_t'(1);
  assign has_left  = lchild < kid_t'(count_r);
  assign has_right = rchild < kid_t'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      next_id_r   <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    pos_r  <= pos_nxt;
    best_r <= best_nxt;
    cur_r  <= cur_nxt;
    bst_r  <= bst_nxt;
    idx_r  <= idx_nxt;
    out_r  <= out_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_item.action)
            ACT_ADD:    state_nxt = (count_r >= cnt_t'(MAX_TIMERS)) ? ST_IDLE : ST_UP_RD;
            ACT_CANCEL: state_nxt = ST_CAN_RD;
            ACT_EXPIRE: state_nxt = ST_EXP_RD;
            default:    state_nxt = ST_WAIT_RD;
          endcase
        end
      end
      ST_UP_RD:  state_nxt = (pos_r == '0) ? ST_IDLE : ST_UP_CMP;
      ST_UP_CMP: state_nxt = a_lt_b ? ST_UP_RD : ST_IDLE;
      ST_CAN_RD: state_nxt = (idx_r >= count_r || req_r.timer_handle == '0) ?
                             ST_IDLE : ST_CAN_CMP;
      ST_CAN_CMP: state_nxt = (rd_data_r[32:1] == req_r.timer_handle) ?
                              ST_IDLE : ST_CAN_RD;
      ST_EXP_RD:  state_nxt = (count_r == '0) ? ST_IDLE : ST_EXP_CMP;
      ST_EXP_CMP: state_nxt = (rd_data_r[EW-1 -: 48] <= req_r.now_ms) ?
                              ST_EXP_LAST : ST_IDLE;
      ST_EXP_LAST: state_nxt = (count_r == '0) ? ST_EXP_RD : ST_DN_RDL;
      ST_DN_RDL:  state_nxt = has_left ? ST_DN_RDR : ST_EXP_RD;
      ST_DN_RDR:  state_nxt = ST_DN_CMP;
      ST_DN_CMP:  state_nxt = (best_nxt != pos_r) ? ST_DN_RDL : ST_EXP_RD;
      ST_WAIT_RD: state_nxt = ST_WAIT_CMP;
      ST_WAIT_CMP: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_nxt     = count_r;
    next_id_nxt   = next_id_r;
    req_nxt       = req_r;
    pos_nxt       = pos_r;
    best_nxt      = best_r;
    cur_nxt       = cur_r;
    bst_nxt       = bst_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    rd_addr       = pos_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = cur_r;
    cmp_a         = cur_r[EW-1 -: 48];
    cmp_b         = rd_data_r[EW-1 -: 48];
    wait_t        = '0;
    case (state_r)
      ST_IDLE: begin
        req_nxt = in_item;
        idx_nxt = '0;
        pos_nxt = '0;
        if (start) begin
          case (in_item.action)
            ACT_ADD: begin
              if (count_r >= cnt_t'(MAX_TIMERS)) begin
                out_valid_nxt = 1'b1;
                out_nxt.kind  = KIND_ADD;
                out_nxt.last  = 1'b1;
              end else begin
                pos_nxt     = addr_t'(count_r);
                count_nxt   = count_r + cnt_t'(1);
                next_id_nxt = (next_id_r == '1) ? 32'd1 : next_id_r + 32'd1;
                cur_nxt     = {48'd0, next_id_r, 1'b0};
                out_nxt.timer_id = next_id_r;
              end
            end
            default: ;
          endcase
        end
      end
      ST_UP_RD: begin
        // First visit fills in the saturated deadline.
        if (idx_r == '0) begin
          cur_nxt[EW-1 -: 48] = dl_sum[48] ? T48_MAX : dl_sum[47:0];
          idx_nxt = cnt_t'(1);
        end
        rd_addr = parent;
        if (pos_r == '0) begin
          wr_en = 1'b1;
          wr_data = cur_nxt;
          out_valid_nxt = 1'b1;
          out_nxt = '{kind: KIND_ADD, timer_id: cur_nxt[32:1], wait_ms: '0,
                      ok_flag: 1'b1, last: 1'b1};
        end
      end
      ST_UP_CMP: begin
        if (a_lt_b) begin
          // Parent moves down into the hole.
          wr_en   = 1'b1;
          wr_data = rd_data_r;
          pos_nxt = parent;
        end else begin
          wr_en = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt = '{kind: KIND_ADD, timer_id: cur_r[32:1], wait_ms: '0,
                      ok_flag: 1'b1, last: 1'b1};
        end
      end
      ST_CAN_RD: begin
        rd_addr = addr_t'(idx_r);
        if (idx_r >= count_r || req_r.timer_handle == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = KIND_CANCEL;
          out_nxt.last  = 1'b1;
        end
      end
      ST_CAN_CMP: begin
        if (rd_data_r[32:1] == req_r.timer_handle) begin
          wr_en   = 1'b1;
          wr_addr = addr_t'(idx_r);
          wr_data = {rd_data_r[EW-1:1], 1'b1};
          out_valid_nxt = 1'b1;
          out_nxt = '{kind: KIND_CANCEL, timer_id: '0, wait_ms: '0,
                      ok_flag: 1'b1, last: 1'b1};
        end else begin
          idx_nxt = idx_r + cnt_t'(1);
        end
      end
      ST_EXP_RD: begin
        rd_addr = '0;
        pos_nxt = '0;
        if (count_r == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = KIND_DONE;
          out_nxt.last  = 1'b1;
        end
      end
      ST_EXP_CMP: begin
        rd_addr = addr_t'(count_r - cnt_t'(1));
        if (rd_data_r[EW-1 -: 48] <= req_r.now_ms) begin
          count_nxt = count_r - cnt_t'(1);
          if (!rd_data_r[0]) begin
            out_valid_nxt    = 1'b1;
            out_nxt.kind     = KIND_FIRED;
            out_nxt.timer_id = rd_data_r[32:1];
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = KIND_DONE;
          out_nxt.last  = 1'b1;
        end
      end
      ST_EXP_LAST: begin
        // Last entry becomes the sinking item.
        cur_nxt = rd_data_r;
      end
      ST_DN_RDL: begin
        rd_addr  = addr_t'(lchild);
        best_nxt = pos_r;
        bst_nxt  = cur_r;
        if (!has_left) begin
          wr_en = 1'b1;
        end
      end
      ST_DN_RDR: begin
        rd_addr = addr_t'(rchild);
        cmp_a   = rd_data_r[EW-1 -: 48];
        cmp_b   = cur_r[EW-1 -: 48];
        if (a_lt_b) begin
          best_nxt = addr_t'(lchild);
          bst_nxt  = rd_data_r;
        end
      end
      ST_DN_CMP: begin
        cmp_a = rd_data_r[EW-1 -: 48];
        cmp_b = bst_r[EW-1 -: 48];
        if (has_right && a_lt_b) begin
          best_nxt = addr_t'(rchild);
          bst_nxt  = rd_data_r;
        end
        if (best_nxt != pos_r) begin
          wr_data = bst_nxt;
          pos_nxt = best_nxt;
        end
        wr_en = 1'b1;
      end
      ST_WAIT_RD: rd_addr = '0;
      ST_WAIT_CMP: begin
        out_valid_nxt = 1'b1;
        out_nxt.kind  = KIND_WAIT;
        out_nxt.last  = 1'b1;
        out_nxt.wait_ms = req_r.wait_cap_ms[31] ? -32'sd1
                        : {1'b0, req_r.wait_cap_ms[30:0]};
        if (count_r != '0) begin
          if (rd_data_r[EW-1 -: 48] > req_r.now_ms) begin
            wait_t = (diff > {16'd0, WAIT_MAX}) ? WAIT_MAX : diff[31:0];
          end
          if (req_r.wait_cap_ms[31] || wait_t < {1'b0, req_r.wait_cap_ms[30:0]}) begin
            out_nxt.wait_ms = wait_t;
          end
        end
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // The entry count never exceeds the heap depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_TIMERS)) else $error("entry count over depth");

  // The id counter never hands out zero.
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != '0) else $error("next id is zero");

  // A final result always lands the sequencer back in idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |-> state_r == ST_IDLE) else $error("last while busy");

  // An accepted add on a non-full heap raises the count by one.
  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.action == ACT_ADD && count_r < cnt_t'(MAX_TIMERS)
    |=> count_r == $past(count_r) + cnt_t'(1)) else $error("add count");

endmodule

FILE: tb/timer_min_heap_queue_tb.sv
module timer_min_heap_queue_tb;
  import tmhq_pkg::*;

  localparam int NumSlots = 32;
  localparam int IdleLimit = 4000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  tmhq_in_t in_item;
  logic out_valid;
  tmhq_out_t out_item;

  timer_min_heap_queue #(.MAX_TIMERS(NumSlots)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // Predicted heap contents.
  logic [47:0] heap_deadline [NumSlots];
  logic [31:0] heap_id [NumSlots];
  logic heap_dead [NumSlots];
  int heap_count;
  logic [31:0] id_counter;
  logic [47:0] clock_now;

  tmhq_out_t pending_results[$];
  int mismatch_count;
  int items_sent;
  int results_seen;
  int fired_seen;
  int idle_cycles;
  int send_gap_pct;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    logic [47:0] d;
    logic [31:0] i;
    logic c;
    d = heap_deadline[a]; i = heap_id[a]; c = heap_dead[a];
    heap_deadline[a] = heap_deadline[b]; heap_id[a] = heap_id[b];
    heap_dead[a] = heap_dead[b];
    heap_deadline[b] = d; heap_id[b] = i; heap_dead[b] = c;
  endfunction

  function automatic void sift_down(input int p);
    int l, r, best;
    forever begin
      l = 2 * p + 1;
      r = 2 * p + 2;
      best = p;
      if (l < heap_count && heap_deadline[l] < heap_deadline[best]) best = l;
      if (r < heap_count && heap_deadline[r] < heap_deadline[best]) best = r;
      if (best == p) break;
      swap_slots(p, best);
      p = best;
    end
  endfunction

  function automatic tmhq_out_t make_result(input logic [2:0] k, input logic [31:0] id,
                                            input logic [31:0] w, input logic ok,
                                            input logic fin);
    tmhq_out_t r;
    r.kind = k; r.timer_id = id; r.wait_ms = w; r.ok_flag = ok; r.last = fin;
    return r;
  endfunction

  // Work out the results of one accepted item and update the predicted heap.
  function automatic void predict_timer_queue(input tmhq_in_t it);
    logic [48:0] sum;
    logic [47:0] dl, time_left;
    logic [31:0] w;
    int p, up;
    logic found;
    case (it.action)
      ACT_ADD: begin
        if (heap_count >= NumSlots) begin
          pending_results.push_back(make_result(KIND_ADD, '0, '0, 1'b0, 1'b1));
        end else begin
          sum = {1'b0, it.now_ms} + {17'd0, it.delay_ms};
          dl = sum[48] ? T48_MAX : sum[47:0];
          p = heap_count;
          heap_deadline[p] = dl; heap_id[p] = id_counter; heap_dead[p] = 1'b0;
          heap_count++;
          while (p > 0) begin
            up = (p - 1) / 2;
            if (heap_deadline[up] <= heap_deadline[p]) break;
            swap_slots(up, p);
            p = up;
          end
          pending_results.push_back(make_result(KIND_ADD, id_counter, '0, 1'b1, 1'b1));
          id_counter = (id_counter == 32'hFFFF_FFFF) ? 32'd1 : id_counter + 32'd1;
        end
      end
      ACT_CANCEL: begin
        found = 1'b0;
        if (it.timer_handle != 0) begin
          for (int i = 0; i < heap_count; i++) begin
            if (heap_id[i] == it.timer_handle) begin
              heap_dead[i] = 1'b1;
              found = 1'b1;
              break;
            end
          end
        end
        pending_results.push_back(make_result(KIND_CANCEL, '0, '0, found, 1'b1));
      end
      ACT_EXPIRE: begin
        while (heap_count > 0 && heap_deadline[0] <= it.now_ms) begin
          if (!heap_dead[0])
            pending_results.push_back(make_result(KIND_FIRED, heap_id[0], '0, 1'b0, 1'b0));
          heap_count--;
          if (heap_count > 0) begin
            heap_deadline[0] = heap_deadline[heap_count];
            heap_id[0] = heap_id[heap_count];
            heap_dead[0] = heap_dead[heap_count];
            sift_down(0);
          end
        end
        pending_results.push_back(make_result(KIND_DONE, '0, '0, 1'b0, 1'b1));
      end
      default: begin
        w = it.wait_cap_ms[31] ? 32'hFFFF_FFFF : it.wait_cap_ms;
        if (heap_count > 0) begin
          time_left = (heap_deadline[0] > it.now_ms) ? heap_deadline[0] - it.now_ms : '0;
          dl = (time_left > {16'd0, WAIT_MAX}) ? {16'd0, WAIT_MAX} : time_left;
          if (it.wait_cap_ms[31] || dl[31:0] < {1'b0, it.wait_cap_ms[30:0]})
            w = dl[31:0];
        end
        pending_results.push_back(make_result(KIND_WAIT, '0, w, 1'b0, 1'b1));
      end
    endcase
  endfunction

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    tmhq_out_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_item.kind == KIND_FIRED) fired_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", out_item.kind));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.kind !== exp_r.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_item.kind, exp_r.kind));
        if (out_item.timer_id !== exp_r.timer_id)
          report_mismatch($sformatf("timer_id %0d, want %0d", out_item.timer_id,
                                    exp_r.timer_id));
        if (out_item.wait_ms !== exp_r.wait_ms)
          report_mismatch($sformatf("wait_ms %0d, want %0d", out_item.wait_ms,
                                    exp_r.wait_ms));
        if (out_item.ok_flag !== exp_r.ok_flag)
          report_mismatch($sformatf("ok_flag %0b, want %0b", out_item.ok_flag,
                                    exp_r.ok_flag));
        if (out_item.last !== exp_r.last)
          report_mismatch($sformatf("last %0b, want %0b", out_item.last, exp_r.last));
      end
    end
  end

  // Watchdog: end the run when nothing is transferred for too long.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog expired with %0d results pending", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Send one item; start stays high across back-to-back transfers.
  task automatic send_item(input logic [1:0] act, input logic [47:0] now,
                           input logic [31:0] dly, input logic [31:0] hdl,
                           input logic [31:0] cap);
    tmhq_in_t it;
    it.action = act; it.now_ms = now; it.delay_ms = dly;
    it.timer_handle = hdl; it.wait_cap_ms = cap;
    if ($urandom_range(99, 0) < send_gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timer_queue(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic finish_sending();
    start <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Extremes: saturating deadline, wait caps, zero handle, empty heap.
  task automatic test_directed_edges();
    send_item(ACT_WAIT, 48'd0, '0, '0, 32'hFFFF_FFFF);
    send_item(ACT_WAIT, 48'd5, '0, '0, 32'h7FFF_FFFF);
    send_item(ACT_EXPIRE, 48'd0, '0, '0, '0);
    send_item(ACT_CANCEL, 48'd0, '0, 32'd0, '0);
    send_item(ACT_ADD, T48_MAX - 48'd3, 32'hFFFF_FFFF, '0, '0);
    send_item(ACT_ADD, 48'd100, 32'hFFFF_FFFF, '0, '0);
    send_item(ACT_ADD, 48'd100, 32'd0, '0, '0);
    send_item(ACT_ADD, 48'd100, 32'd0, '0, '0);
    send_item(ACT_WAIT, 48'd0, '0, '0, 32'h8000_0000);
    send_item(ACT_WAIT, 48'd50, '0, '0, 32'd10);
    send_item(ACT_WAIT, 48'd200, '0, '0, 32'd0);
    send_item(ACT_CANCEL, 48'd0, '0, 32'd3, '0);
    send_item(ACT_CANCEL, 48'd0, '0, 32'd3, '0);
    send_item(ACT_CANCEL, 48'd0, '0, 32'hFFFF_FFFF, '0);
    send_item(ACT_EXPIRE, 48'd100, '0, '0, '0);
    send_item(ACT_WAIT, 48'd0, '0, '0, 32'hFFFF_FFFF);
    send_item(ACT_EXPIRE, T48_MAX, '0, '0, '0);
    finish_sending();
    drain_results();
  endtask

  // Fill past capacity, then expire everything at once.
  task automatic test_full_heap();
    for (int i = 0; i < NumSlots + 2; i++)
      send_item(ACT_ADD, 48'd1000, $urandom_range(40, 0), '0, '0);
    send_item(ACT_CANCEL, 48'd0, '0, id_counter - 32'd5, '0);
    send_item(ACT_EXPIRE, 48'd1040, '0, '0, '0);
    finish_sending();
    drain_results();
  endtask

  function automatic logic [47:0] rand_now();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // Random sequences around a moving clock, with some wild values mixed in.
  task automatic test_random_mix(input int count);
    logic [31:0] hdl, cap, dly;
    logic [47:0] now;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99, 0);
      now = ($urandom_range(9, 0) == 0) ? rand_now() : clock_now;
      dly = ($urandom_range(9, 0) == 0) ? $urandom : $urandom_range(60, 0);
      hdl = ($urandom_range(4, 0) == 0) ? $urandom : id_counter - $urandom_range(8, 1);
      cap = ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(40, 0);
      if (r < 45) begin
        send_item(ACT_ADD, now, dly, hdl, cap);
      end else if (r < 60) begin
        send_item(ACT_CANCEL, now, dly, hdl, cap);
      end else if (r < 80) begin
        clock_now = clock_now + $urandom_range(40, 0);
        send_item(ACT_EXPIRE, clock_now, dly, hdl, cap);
      end else begin
        send_item(ACT_WAIT, now, dly, hdl, cap);
      end
    end
    send_item(ACT_EXPIRE, T48_MAX, '0, '0, '0);
    finish_sending();
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    heap_count = 0;
    id_counter = 32'd1;
    clock_now = 48'd5000;
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    fired_seen = 0;
    idle_cycles = 0;
    send_gap_pct = 13;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_edges();
    test_full_heap();
    test_random_mix(42);
    send_gap_pct = 56;
    test_random_mix(42);
    send_gap_pct = 0;
    test_random_mix(42);
    $display("Sent %0d items, checked %0d results (%0d timers fired).",
             items_sent, results_seen, fired_seen);
    $display("Covered saturation, full heap, cancels, expiry and wait caps.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: timer_min_heap_queue.f
hdl/tmhq_pkg.sv
hdl/timer_min_heap_queue.sv
tb/timer_min_heap_queue_tb.sv
